// ===== hdl/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table package
// Operation and status codes, data width and the command that the table
// broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned POS_W = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hdl/sorted_table_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Sorted table engine
// Keeps up to CAPACITY signed values in ascending order in a row of cells
// and serves insert, remove and read operations.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and busy is never raised.
// Each item's result appears on the out_ ports in the cycle after the item is
// accepted, marked by out_strobe for exactly one cycle; the receiver cannot
// stall it. All cells compare their entry with the item's value in the same
// cycle and shift in step, so the whole row updates together whatever
// the fill level. The count reported is taken modulo 32.
module sorted_table_insert_remove #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_kind,
  input  logic signed [sti_pkg::DATA_W-1:0]      in_value,
  input  logic [sti_pkg::POS_W-1:0]              in_position,
  output logic                                   out_strobe,
  output logic signed [sti_pkg::DATA_W-1:0]      out_read_value,
  output logic [1:0]                             out_status,
  output logic [sti_pkg::COUNT_W-1:0]            out_count
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > sti_pkg::POS_W) ? CNT_W : sti_pkg::POS_W;
  localparam int unsigned RD_N  = (CAPACITY < 16) ? CAPACITY : 16;

  logic                              accept;
  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic                              full;
  logic                              found;
  logic                              ins_ok;
  logic                              rem_ok;
  logic [CMP_W-1:0]                  pos_ext;
  logic [CMP_W-1:0]                  cnt_ext;
  logic signed [sti_pkg::DATA_W-1:0] rd_val;
  logic signed [sti_pkg::DATA_W-1:0] rd_sel;
  logic [1:0]                        status;
  sti_pkg::cell_cmd_t                cmd;

  logic signed [sti_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]               cell_sh;
  logic [CAPACITY-1:0]               cell_eq;
  logic [CAPACITY-1:0]               cell_valid;

  logic                              out_strobe_r;
  logic signed [sti_pkg::DATA_W-1:0] out_read_value_r;
  logic [1:0]                        out_status_r;
  logic [sti_pkg::COUNT_W-1:0]       out_count_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign found  = |cell_eq;
  assign ins_ok = accept && (in_kind == sti_pkg::KIND_INSERT) && !full;
  assign rem_ok = accept && (in_kind == sti_pkg::KIND_REMOVE) && found;

  assign cmd.ins   = ins_ok;
  assign cmd.rem   = rem_ok;
  assign cmd.value = in_value;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign cell_valid[g] = (CNT_W'(g) < count_r);
      if (g == 0) begin : g_first
        sti_cell u_cell (
          .clk       (clk),
          .cmd       (cmd),
          .valid     (cell_valid[g]),
          .left_val  (in_value),
          .left_sh   (1'b0),
          .right_val ((CAPACITY > 1) ? cell_val[(CAPACITY > 1) ? 1 : 0] : cell_val[0]),
          .entry     (cell_val[g]),
          .sh        (cell_sh[g]),
          .eq        (cell_eq[g])
        );
      end else if (g == CAPACITY - 1) begin : g_last
        sti_cell u_cell (
          .clk       (clk),
          .cmd       (cmd),
          .valid     (cell_valid[g]),
          .left_val  (cell_val[g-1]),
          .left_sh   (cell_sh[g-1]),
          .right_val (cell_val[g]),
          .entry     (cell_val[g]),
          .sh        (cell_sh[g]),
          .eq        (cell_eq[g])
        );
      end else begin : g_mid
        sti_cell u_cell (
          .clk       (clk),
          .cmd       (cmd),
          .valid     (cell_valid[g]),
          .left_val  (cell_val[g-1]),
          .left_sh   (cell_sh[g-1]),
          .right_val (cell_val[g+1]),
          .entry     (cell_val[g]),
          .sh        (cell_sh[g]),
          .eq        (cell_eq[g])
        );
      end
    end
  endgenerate

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_ext == CMP_W'(i)) begin
        rd_sel = cell_val[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    rd_val    = '0;
    status    = sti_pkg::ST_RANGE;
    case (in_kind)
      sti_pkg::KIND_INSERT: begin
        if (full) begin
          status = sti_pkg::ST_FULL;
        end else begin
          status    = sti_pkg::ST_OK;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      sti_pkg::KIND_REMOVE: begin
        if (found) begin
          status    = sti_pkg::ST_OK;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status = sti_pkg::ST_NOT_FOUND;
        end
      end
      sti_pkg::KIND_READ: begin
        if (pos_ext < cnt_ext) begin
          status = sti_pkg::ST_OK;
          rd_val = rd_sel;
        end
      end
      default: begin
        status = sti_pkg::ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= rd_val;
      out_status_r     <= status;
      out_count_r      <= sti_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  // The fill level never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every accepted item gives exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe_r)
    else $error("accepted item without result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_strobe_r)
    else $error("result without accepted item");

  // A successful insert grows the table by one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table");

  // Only a successful read carries a nonzero value.
  a_read_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_status_r != sti_pkg::ST_OK)) |-> (out_read_value_r == '0))
    else $error("nonzero read value on a failed operation");

endmodule

// ===== hdl/sti_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one entry, compares it with the broadcast value and, when the row
// shifts, takes the entry of its left or right neighbor or the new value.
// ----------------------------------------------------------------------------
module sti_cell (
  input  logic                                  clk,
  input  sti_pkg::cell_cmd_t                    cmd,
  input  logic                                  valid,
  input  logic signed [sti_pkg::DATA_W-1:0]     left_val,
  input  logic                                  left_sh,
  input  logic signed [sti_pkg::DATA_W-1:0]     right_val,
  output logic signed [sti_pkg::DATA_W-1:0]     entry,
  output logic                                  sh,
  output logic                                  eq
);

  logic signed [sti_pkg::DATA_W-1:0] entry_r;
  logic signed [sti_pkg::DATA_W-1:0] entry_nxt;
  logic                              ge;

  assign entry = entry_r;
  assign sh    = !valid || (cmd.value < entry_r);
  assign ge    = valid && !(entry_r < cmd.value);
  assign eq    = valid && (entry_r == cmd.value);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && sh) begin
      entry_nxt = left_sh ? left_val : cmd.value;
    end else if (cmd.rem && ge) begin
      entry_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== bench/tb_sorted_table_insert_remove.sv =====
// ----------------------------------------------------------------------------
// Sorted table engine testbench
// Drives insert, remove, read and no-op items into the table, predicts every result
// with a software copy of the sorted table, and checks each strobed result
// against the oldest outstanding prediction under several sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_table_insert_remove;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 238;
  localparam logic signed [sti_pkg::DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [sti_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [sti_pkg::DATA_W-1:0] read_value;
    sti_pkg::status_t                  status;
    logic [sti_pkg::COUNT_W-1:0]       count;
  } table_result_t;

  class table_scoreboard;
    logic signed [sti_pkg::DATA_W-1:0] held[TABLE_DEPTH];
    int unsigned                       held_count;
    table_result_t                     awaited[$];
    int unsigned                       errors;
    int unsigned                       checked;
    int unsigned                       status_seen[4];

    function new();
      held_count = 0;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function logic signed [sti_pkg::DATA_W-1:0] pick_present();
      return held[$urandom_range(held_count - 1)];
    endfunction

    function void note_item(sti_pkg::kind_t kind,
                            logic signed [sti_pkg::DATA_W-1:0] value,
                            logic [sti_pkg::POS_W-1:0] position);
      table_result_t res;
      int unsigned   slot;
      res.read_value = '0;
      res.status = sti_pkg::ST_OK;
      slot = 0;
      case (kind)
        sti_pkg::KIND_INSERT: begin
          if (held_count >= TABLE_DEPTH) begin
            res.status = sti_pkg::ST_FULL;
          end else begin
            while (slot < held_count && !(value < held[slot])) slot++;
            for (int unsigned i = held_count; i > slot; i--) held[i] = held[i-1];
            held[slot] = value;
            held_count++;
          end
        end
        sti_pkg::KIND_REMOVE: begin
          while (slot < held_count && held[slot] !== value) slot++;
          if (slot >= held_count) begin
            res.status = sti_pkg::ST_NOT_FOUND;
          end else begin
            for (int unsigned i = slot; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end
        end
        sti_pkg::KIND_READ: begin
          if (position < held_count) begin
            res.read_value = held[position];
          end else begin
            res.status = sti_pkg::ST_RANGE;
          end
        end
        default: begin
          res.status = sti_pkg::ST_RANGE;
        end
      endcase
      res.count = held_count[sti_pkg::COUNT_W-1:0];
      awaited.push_back(res);
    endfunction

    task check_result(logic signed [sti_pkg::DATA_W-1:0] read_value, logic [1:0] status,
                      logic [sti_pkg::COUNT_W-1:0] count);
      table_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result strobed with no item outstanding");
        return;
      end
      want = awaited.pop_front();
      checked++;
      status_seen[want.status]++;
      if (read_value !== want.read_value)
        report_mismatch($sformatf("result %0d read_value %0d, expected %0d",
                                  checked, read_value, want.read_value));
      if (status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  checked, status, want.status));
      if (count !== want.count)
        report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                  checked, count, want.count));
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_kind = 2'd0;
  logic signed [sti_pkg::DATA_W-1:0] in_value = '0;
  logic [sti_pkg::POS_W-1:0]         in_position = '0;
  logic                              out_strobe;
  logic signed [sti_pkg::DATA_W-1:0] out_read_value;
  logic [1:0]                        out_status;
  logic [sti_pkg::COUNT_W-1:0]       out_count;

  table_scoreboard sb = new();
  int unsigned     idle_pct = 0;
  int unsigned     items_sent = 0;
  int unsigned     cycles = 0;

  sorted_table_insert_remove #(
    .CAPACITY(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_value(in_value),
    .in_position(in_position),
    .out_strobe(out_strobe),
    .out_read_value(out_read_value),
    .out_status(out_status),
    .out_count(out_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_strobe === 1'b1) sb.check_result(out_read_value, out_status, out_count);
  end

  task automatic send_item(sti_pkg::kind_t kind, logic signed [sti_pkg::DATA_W-1:0] value,
                           logic [sti_pkg::POS_W-1:0] position);
    start <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    in_position <= position;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(kind, value, position);
    items_sent++;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_value <= $urandom;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [sti_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $signed($urandom_range(7)) - 4;
      5: begin
        case ($urandom_range(3))
          0: return VALUE_MIN;
          1: return VALUE_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    send_item(sti_pkg::KIND_READ, 0, 4'd0);
    send_item(sti_pkg::KIND_REMOVE, 5, 4'd0);
    send_item(sti_pkg::KIND_NONE, -1, 4'd15);
    send_item(sti_pkg::KIND_INSERT, VALUE_MAX, 4'd0);
    send_item(sti_pkg::KIND_INSERT, VALUE_MIN, 4'd0);
    send_item(sti_pkg::KIND_INSERT, 0, 4'd0);
    send_item(sti_pkg::KIND_INSERT, 0, 4'd0);
    send_item(sti_pkg::KIND_INSERT, -1, 4'd0);
    send_item(sti_pkg::KIND_READ, 0, 4'd0);
    send_item(sti_pkg::KIND_READ, 0, 4'd5);
    for (int i = 0; i < 11; i++) send_item(sti_pkg::KIND_INSERT, rand_value(), 4'd0);
    send_item(sti_pkg::KIND_INSERT, 7, 4'd0);
    send_item(sti_pkg::KIND_READ, 0, 4'd15);
    send_item(sti_pkg::KIND_REMOVE, 0, 4'd0);
    send_item(sti_pkg::KIND_REMOVE, 12345, 4'd0);
    send_item(sti_pkg::KIND_REMOVE, VALUE_MIN, 4'd0);
    send_item(sti_pkg::KIND_REMOVE, VALUE_MAX, 4'd0);
  endtask

  task automatic run_random(int unsigned n, int unsigned pct);
    int unsigned                       fill_bias;
    int unsigned                       r;
    sti_pkg::kind_t                    kind;
    logic signed [sti_pkg::DATA_W-1:0] value;
    logic [sti_pkg::POS_W-1:0]         position;
    idle_pct = pct;
    fill_bias = $urandom_range(1) ? 75 : 25;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 39) fill_bias = (fill_bias == 75) ? 25 : 75;
      r = $urandom_range(99);
      value = rand_value();
      position = sti_pkg::POS_W'($urandom_range(15));
      if (r < 4) begin
        kind = sti_pkg::KIND_NONE;
      end else if (r < 22) begin
        kind = sti_pkg::KIND_READ;
        if (sb.held_count > 0 && $urandom_range(1))
          position = sti_pkg::POS_W'($urandom_range(sb.held_count - 1));
      end else if ($urandom_range(99) < fill_bias) begin
        kind = sti_pkg::KIND_INSERT;
      end else begin
        kind = sti_pkg::KIND_REMOVE;
        if (sb.held_count > 0 && $urandom_range(2) != 0) value = sb.pick_present();
      end
      send_item(kind, value, position);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(ITEMS_PER_PHASE, 0);
    run_random(ITEMS_PER_PHASE, 54);
    run_random(ITEMS_PER_PHASE, 0);
    run_random(ITEMS_PER_PHASE, 34);
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d items at sender idle rates of 0, 54 and 34 percent.", items_sent);
    $display("Checked %0d results: %0d ok, %0d not found, %0d out of range, %0d full.",
             sb.checked, sb.status_seen[sti_pkg::ST_OK],
             sb.status_seen[sti_pkg::ST_NOT_FOUND],
             sb.status_seen[sti_pkg::ST_RANGE], sb.status_seen[sti_pkg::ST_FULL]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sti_pkg.sv
hdl/sti_cell.sv
hdl/sorted_table_insert_remove.sv
bench/tb_sorted_table_insert_remove.sv
